@@ rtl/core/dls_pkg.sv @@
// Shared constants, codes and types for the fixed-point DDA line stepper.
// No dependencies.
package dls_pkg;

  localparam int COORD_BITS  = 10;
  localparam int FRAC_BITS   = 8;
  localparam int COLOR_BITS  = 32;
  localparam int ACC_BITS    = COORD_BITS + FRAC_BITS;
  localparam int SLOPE_BITS  = FRAC_BITS + 2;
  localparam int QUOT_BITS   = FRAC_BITS + 1;
  localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);
  localparam int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 * COORD_BITS + COLOR_BITS;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [QUOT_BITS-1:0] quot;
  } dls_div_sts_t;

endpackage

@@ rtl/core/dls_div.sv @@
// Restoring radix-2 divider for the slope: quot = (num << FRAC_BITS) / den, num <= den.
// One quotient bit per cycle. Depends on dls_pkg.
module dls_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [dls_pkg::COORD_BITS-1:0]  num,
  input  logic [dls_pkg::COORD_BITS-1:0]  den,
  output dls_pkg::dls_div_sts_t           sts
);

  logic [dls_pkg::COORD_BITS:0]     rem_r, rem_nxt;
  logic [dls_pkg::COORD_BITS-1:0]   den_r, den_nxt;
  logic [dls_pkg::QUOT_BITS-1:0]    quot_r, quot_nxt;
  logic [dls_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [dls_pkg::COORD_BITS+1:0]   diff;
  logic                             ge;
  logic [dls_pkg::COORD_BITS:0]     rem_after;

  assign diff      = {1'b0, rem_r} - {2'b00, den_r};
  assign ge        = ~diff[dls_pkg::COORD_BITS+1];
  assign rem_after = ge ? diff[dls_pkg::COORD_BITS:0] : rem_r;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start && !busy_r) begin
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      quot_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = {rem_after[dls_pkg::COORD_BITS-1:0], 1'b0};
      quot_nxt = {quot_r[dls_pkg::QUOT_BITS-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == dls_pkg::DIV_CNT_W'(dls_pkg::FRAC_BITS)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.quot = quot_r;

endmodule

@@ rtl/core/fixed_point_dda_line_stepper.sv @@
// Fixed-point DDA line stepper: load a segment, then emit one pixel per step item while the line is active.
// A step item shows its pixel on the output register in the next cycle;
// steps sustain one item per cycle while the output is drained.
// A load with a nonzero major length holds in_tready low while the divider steps, then the slope is written.
// Reset (rst_n low, synchronous) clears the color, the line state (but for the sign flag) and the divider control.
// Depends on dls_pkg and dls_div.
module fixed_point_dda_line_stepper (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dls_pkg::IN_TDATA_W-1:0]    in_tdata,   // x_start, y_start, x_end, y_end
  input  logic                              in_tuser,   // action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [dls_pkg::OUT_TDATA_W-1:0]   out_tdata,  // pixel_x, pixel_y, pixel_color, pad
  output logic                              out_tlast,  // last_pixel
  input  logic                              cfg_wr_en,
  input  logic [dls_pkg::COLOR_BITS-1:0]    cfg_wr_data
);

  localparam int CW = dls_pkg::COORD_BITS;
  localparam int FW = dls_pkg::FRAC_BITS;
  localparam int AW = dls_pkg::ACC_BITS;
  localparam int SW = dls_pkg::SLOPE_BITS;

  logic                          state_r, state_nxt;
  logic [dls_pkg::COLOR_BITS-1:0] color_r;
  logic [CW-1:0]                 major_pos_r, major_pos_nxt;
  logic [CW-1:0]                 major_stop_r, major_stop_nxt;
  logic [AW-1:0]                 accum_r, accum_nxt;
  logic [SW-1:0]                 slope_r, slope_nxt;
  logic                          swapped_r, swapped_nxt;
  logic                          active_r, active_nxt;
  logic                          neg_r, neg_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [CW-1:0]                 out_x_r, out_x_nxt;
  logic [CW-1:0]                 out_y_r, out_y_nxt;
  logic [dls_pkg::COLOR_BITS-1:0] out_color_r, out_color_nxt;
  logic                          out_last_r, out_last_nxt;

  logic [CW-1:0] x0, y0, x1, y1;
  logic [CW-1:0] adx, ady;
  logic          swap;
  logic [CW-1:0] ma0, ma1, mi0, mi1;
  logic [CW-1:0] sma0, sma1, smi0, smi1;
  logic [CW-1:0] dmaj, mag;
  logic          dmin_neg;
  logic          in_acc;
  logic          div_start;
  logic          last;
  logic [SW-1:0] q_ext;
  dls_pkg::dls_div_sts_t div_sts;

  assign x0 = in_tdata[CW-1:0];
  assign y0 = in_tdata[2*CW-1:CW];
  assign x1 = in_tdata[3*CW-1:2*CW];
  assign y1 = in_tdata[4*CW-1:3*CW];

  always_comb begin
    adx  = (x1 >= x0) ? x1 - x0 : x0 - x1;
    ady  = (y1 >= y0) ? y1 - y0 : y0 - y1;
    swap = adx < ady;
    ma0  = swap ? y0 : x0;
    ma1  = swap ? y1 : x1;
    mi0  = swap ? x0 : y0;
    mi1  = swap ? x1 : y1;
    if (ma1 < ma0) begin
      sma0 = ma1; sma1 = ma0; smi0 = mi1; smi1 = mi0;
    end else begin
      sma0 = ma0; sma1 = ma1; smi0 = mi0; smi1 = mi1;
    end
    dmaj     = sma1 - sma0;
    dmin_neg = smi1 < smi0;
    mag      = dmin_neg ? smi0 - smi1 : smi1 - smi0;
  end

  assign in_tready = (state_r == dls_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign last      = ({1'b0, major_pos_r} + 1'b1) == {1'b0, major_stop_r};
  assign q_ext     = {1'b0, div_sts.quot};

  always_comb begin
    state_nxt      = state_r;
    major_pos_nxt  = major_pos_r;
    major_stop_nxt = major_stop_r;
    accum_nxt      = accum_r;
    slope_nxt      = slope_r;
    swapped_nxt    = swapped_r;
    active_nxt     = active_r;
    neg_nxt        = neg_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_color_nxt  = out_color_r;
    out_last_nxt   = out_last_r;
    div_start      = 1'b0;
    case (state_r)
      dls_pkg::ST_IDLE: begin
        if (in_acc && in_tuser == dls_pkg::ACT_LOAD) begin
          major_pos_nxt  = sma0;
          major_stop_nxt = sma1;
          accum_nxt      = {smi0, {FW{1'b0}}};
          swapped_nxt    = swap;
          neg_nxt        = dmin_neg;
          slope_nxt      = '0;
          active_nxt     = 1'b0;
          if (dmaj != '0) begin
            div_start = 1'b1;
            state_nxt = dls_pkg::ST_DIV;
          end
        end else if (in_acc && active_r) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = swapped_r ? accum_r[AW-1:FW] : major_pos_r;
          out_y_nxt     = swapped_r ? major_pos_r : accum_r[AW-1:FW];
          out_color_nxt = color_r;
          out_last_nxt  = last;
          major_pos_nxt = major_pos_r + 1'b1;
          accum_nxt     = accum_r + {{(AW-SW){slope_r[SW-1]}}, slope_r};
          if (last) active_nxt = 1'b0;
        end
      end
      dls_pkg::ST_DIV: begin
        if (div_sts.done) begin
          slope_nxt  = neg_r ? -q_ext : q_ext;
          active_nxt = 1'b1;
          state_nxt  = dls_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dls_pkg::ST_IDLE;
    endcase
  end

  dls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mag),
    .den   (dmaj),
    .sts   (div_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dls_pkg::ST_IDLE;
      color_r      <= '0;
      major_pos_r  <= '0;
      major_stop_r <= '0;
      accum_r      <= '0;
      slope_r      <= '0;
      swapped_r    <= 1'b0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      color_r      <= cfg_wr_en ? cfg_wr_data : color_r;
      major_pos_r  <= major_pos_nxt;
      major_stop_r <= major_stop_nxt;
      accum_r      <= accum_nxt;
      slope_r      <= slope_nxt;
      swapped_r    <= swapped_nxt;
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r       <= neg_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_color_r <= out_color_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(dls_pkg::OUT_TDATA_W - dls_pkg::OUT_FIELD_W){1'b0}},
                       out_color_r, out_y_r, out_x_r};

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.busy |-> !in_tready)
    else $error("input ready while slope divider busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> state_r == dls_pkg::ST_DIV)
    else $error("divider finished outside the divide state");

  a_step_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == dls_pkg::ACT_STEP && active_r) |=> out_tvalid)
    else $error("step on an active line produced no pixel");

endmodule
